// File: src/brle_pkg.sv
// Shared types and constants for the bit run-length encoder.
// Used by the input queue, the bit scanner and the top level; depends on nothing.
package brle_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned COUNT_W     = 31;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;

    // Largest run length minus one that the count field can hold.
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // One input item as it sits in the queue.
    typedef struct packed {
        logic [DATA_W-1:0] data_word;
        logic              end_of_stream;
    } item_t;

    // One result item as it sits in the output register.
    typedef struct packed {
        logic [DATA_W-1:0] run_word;
        logic              last_of_item;
        logic              final_run;
    } result_t;

    // Sequencer states of the bit scanner.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FLUSH
    } scan_state_t;

endpackage

// File: src/brle_queue.sv
// Input queue of the encoder: a short register queue between the port and the scanner.
// Depends on brle_pkg for the item type and the queue depth.
module brle_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  brle_pkg::item_t in_item,
    output logic            in_stall,
    output logic            out_valid,
    output brle_pkg::item_t out_item,
    input  logic            out_take
);
    import brle_pkg::*;

    item_t             entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   fill_reg;
    logic [QPTR_W:0]   fill_next;
    logic              push;
    logic              pop;

    // The queue is full or empty by its fill count alone.
    assign in_stall  = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_item  = entries_reg[rd_ptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = out_take && out_valid;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0
                                                               : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0
                                                               : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (QPTR_W+1)'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= in_item;
        end
    end

    // The fill count never passes the depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue fill count above depth");

endmodule

// File: src/brle_scan.sv
// Bit scanner: walks each word one bit per cycle when the output is not stalled, tracks
// the pending run, drives the output register. Uses brle_pkg types, states, constants.
module brle_scan #(
    parameter int unsigned WORD_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  brle_pkg::item_t   item,
    output logic              item_take,
    output logic              out_valid,
    output brle_pkg::result_t out_result,
    input  logic              out_stall
);
    import brle_pkg::*;

    localparam int unsigned CNT_W = $clog2(WORD_BITS);

    scan_state_t          state_reg;
    scan_state_t          state_next;
    logic [WORD_BITS-1:0] shift_reg;
    logic [WORD_BITS-1:0] shift_next;
    logic [CNT_W-1:0]     bits_left_reg;
    logic [CNT_W-1:0]     bits_left_next;
    logic                 eos_reg;
    logic                 eos_next;
    logic                 run_bit_reg;
    logic                 run_bit_next;
    logic [COUNT_W-1:0]   run_count_reg;
    logic [COUNT_W-1:0]   run_count_next;
    logic                 run_started_reg;
    logic                 run_started_next;
    logic                 held_valid_reg;
    logic                 held_valid_next;
    logic [DATA_W-1:0]    held_word_reg;
    logic [DATA_W-1:0]    held_word_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    result_t              out_reg;
    result_t              out_next;

    logic                 can_push;
    logic                 push;
    result_t              push_val;
    logic                 cur_bit;
    logic                 scan_emit;
    logic [DATA_W-1:0]    emit_word;
    logic                 advance;
    logic                 done;
    logic                 load_ok;

    assign can_push   = !out_valid_reg || !out_stall;
    assign cur_bit    = shift_reg[WORD_BITS-1];
    assign emit_word  = {run_bit_reg, run_count_reg};
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // Run decision for the bit at the head of the shift register.
    always_comb
    begin
        scan_emit = 1'b0;
        if (run_started_reg)
        begin
            if (cur_bit != run_bit_reg)
            begin
                scan_emit = 1'b1;
            end
            else if (run_count_reg == COUNT_MAX)
            begin
                scan_emit = 1'b1;
            end
        end
    end

    // A finished run is held back until it is known whether it ends the item's results.
    assign advance = !(scan_emit && held_valid_reg) || can_push;

    // Sequencer: next state, run tracking, pushes into the output register.
    always_comb
    begin
        state_next       = state_reg;
        shift_next       = shift_reg;
        bits_left_next   = bits_left_reg;
        eos_next         = eos_reg;
        run_bit_next     = run_bit_reg;
        run_count_next   = run_count_reg;
        run_started_next = run_started_reg;
        held_valid_next  = held_valid_reg;
        held_word_next   = held_word_reg;
        push             = 1'b0;
        push_val         = '0;
        done             = 1'b0;
        load_ok          = 1'b0;
        item_take        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                load_ok = 1'b1;
            end
            S_SCAN:
            begin
                if (advance)
                begin
                    if (!run_started_reg)
                    begin
                        run_bit_next     = cur_bit;
                        run_count_next   = '0;
                        run_started_next = 1'b1;
                    end
                    else if (cur_bit == run_bit_reg && run_count_reg != COUNT_MAX)
                    begin
                        run_count_next = run_count_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        run_bit_next   = cur_bit;
                        run_count_next = '0;
                    end
                    if (scan_emit)
                    begin
                        if (held_valid_reg)
                        begin
                            push     = 1'b1;
                            push_val = '{run_word: held_word_reg, last_of_item: 1'b0,
                                         final_run: 1'b0};
                        end
                        held_valid_next = 1'b1;
                        held_word_next  = emit_word;
                    end
                    shift_next     = shift_reg << 1;
                    bits_left_next = bits_left_reg - CNT_W'(1);
                    if (bits_left_reg == '0)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (!held_valid_reg)
                begin
                    if (eos_reg)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                else if (can_push)
                begin
                    push            = 1'b1;
                    push_val        = '{run_word: held_word_reg, last_of_item: !eos_reg,
                                        final_run: 1'b0};
                    held_valid_next = 1'b0;
                    if (eos_reg)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
            end
            S_FLUSH:
            begin
                if (can_push)
                begin
                    push             = 1'b1;
                    push_val         = '{run_word: emit_word, last_of_item: 1'b1,
                                         final_run: 1'b1};
                    run_bit_next     = 1'b0;
                    run_count_next   = '0;
                    run_started_next = 1'b0;
                    done             = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The next item is loaded as soon as the current one has finished.
        if (done)
        begin
            state_next = S_IDLE;
            load_ok    = 1'b1;
        end
        if (load_ok && item_valid)
        begin
            item_take      = 1'b1;
            shift_next     = WORD_BITS'(item.data_word);
            bits_left_next = CNT_W'(WORD_BITS - 1);
            eos_next       = item.end_of_stream;
            state_next     = S_SCAN;
        end
    end

    // Output register: loads on a push, empties once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_next       = push_val;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and run state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            run_bit_reg     <= 1'b0;
            run_count_reg   <= '0;
            run_started_reg <= 1'b0;
            held_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            run_bit_reg     <= run_bit_next;
            run_count_reg   <= run_count_next;
            run_started_reg <= run_started_next;
            held_valid_reg  <= held_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        shift_reg     <= shift_next;
        bits_left_reg <= bits_left_next;
        eos_reg       <= eos_next;
        held_word_reg <= held_word_next;
        out_reg       <= out_next;
    end

    // A new item is only taken between scans.
    a_take_not_scanning: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |-> (state_reg != S_SCAN))
        else $error("item taken in the middle of a scan");

    // No held run survives the end of an item.
    a_idle_nothing_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !held_valid_reg)
        else $error("held run left over while idle");

    // The flush always has a pending run and nothing held ahead of it.
    a_flush_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |-> (run_started_reg && !held_valid_reg))
        else $error("flush without a pending run");

    // The stream's final run is always the last result of its item.
    a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.final_run) |-> out_reg.last_of_item)
        else $error("final run not marked last of item");

endmodule

// File: src/bit_run_length_encoder_core.sv
// Bit run-length encoder, top level: input queue feeding the scanner, which examines
// one bit per cycle unless output stalls hold it. An item is registered in the queue,
// then scanned bit by bit in the scan state, then passes the drain state, and the flush
// state as well when end_of_stream is set. The scanner takes the next item only as the
// current one finishes, and output stalls can lengthen the scan, drain and flush.
// Reset: rst_n clears the queue, the output register and the run state (no run pending).
module bit_run_length_encoder_core #(
    parameter int unsigned WORD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] run_word,
    output logic        last_of_item,
    output logic        final_run
);
    import brle_pkg::*;

    item_t   in_item;
    item_t   q_item;
    logic    q_valid;
    logic    q_take;
    result_t result;

    assign in_item = '{data_word: data_word, end_of_stream: end_of_stream};

    // Front: queue that accepts items independently of the scanner.
    brle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .in_stall  (in_stall),
        .out_valid (q_valid),
        .out_item  (q_item),
        .out_take  (q_take)
    );

    // Back: bit scanner and output register.
    brle_scan #(
        .WORD_BITS (WORD_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item       (q_item),
        .item_take  (q_take),
        .out_valid  (out_valid),
        .out_result (result),
        .out_stall  (out_stall)
    );

    assign run_word     = result.run_word;
    assign last_of_item = result.last_of_item;
    assign final_run    = result.final_run;

endmodule
